>>> rtl/core/nbm_pkg.sv
`default_nettype none

package nbm_pkg;

  // Address decode: only bits [15:12] and [1:0] survive the 0xF003 mask.
  localparam logic [3:0] PagePrgA  = 4'h8;
  localparam logic [3:0] PagePrgB  = 4'h9;
  localparam logic [3:0] PageChr0  = 4'hA;
  localparam logic [3:0] PageChr1  = 4'hB;
  localparam logic [3:0] PageChr2  = 4'hC;
  localparam logic [3:0] PageChr3  = 4'hD;
  localparam logic [3:0] PageRel   = 4'hE;
  localparam logic [3:0] PageCtl   = 4'hF;

  localparam logic [1:0] RegCntLoad = 2'd0;
  localparam logic [1:0] RegIrqCtrl = 2'd1;
  localparam logic [1:0] RegMirror  = 2'd2;

  localparam logic [3:0] ChrSlotBase = 4'd3;
  localparam int unsigned NumBanks   = 11;

  localparam logic [15:0] Mask4  = 16'h000F;
  localparam logic [15:0] Mask8  = 16'h00FF;
  localparam logic [15:0] Mask12 = 16'h0FFF;
  localparam logic [15:0] Mask16 = 16'hFFFF;

  // Per-beat control from the decoder, already qualified by the advance strobe.
  typedef struct packed {
    logic       tick;
    logic       bank_we;
    logic [3:0] slot;
    logic       hi;
    logic       reload_we;
    logic [1:0] nib_sel;
    logic       count_load;
    logic       ctrl_we;
    logic       mirror_we;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/nibble_bank_mapper_irq_counter.sv
// A beat accepted into the input register goes through the decode, bank and IRQ logic
// into the result register. Throughput: one beat per cycle while the result register
// is empty or being drained, set by the input register feeding the decode, bank and
// IRQ logic, which updates the state and loads the result register together.
// Reset clears all bank registers, the IRQ reload value, counter, width mask,
// enable and pending flags, and empties both pipeline registers.
`default_nettype none

module nibble_bank_mapper_irq_counter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             irq_line_o,
  output logic             bank_update_o,
  output logic [3:0]       bank_slot_o,
  output logic [7:0]       bank_number_o,
  output logic             mirror_update_o,
  output logic [1:0]       mirroring_o
);
  import nbm_pkg::*;

  logic        in_valid_q;
  logic        mode_q;
  logic [15:0] address_q;
  logic [7:0]  value_q;
  logic        out_valid_q;
  logic        advance;
  ctl_t        ctl;
  logic [7:0]  number;
  logic        irq_line;

  logic        irq_line_q;
  logic        bank_update_q;
  logic [3:0]  bank_slot_q;
  logic [7:0]  bank_number_q;
  logic        mirror_update_q;
  logic [1:0]  mirroring_q;

  // The held beat moves on whenever the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q    <= mode_i;
      address_q <= address_i;
      value_q   <= value_i;
    end
  end

  nbm_decode u_decode (
    .fire_i    (advance),
    .mode_i    (mode_q),
    .address_i (address_q),
    .ctl_o     (ctl)
  );

  nbm_banks u_banks (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .nib_i    (value_q[3:0]),
    .number_o (number)
  );

  nbm_irq u_irq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .nib_i      (value_q[3:0]),
    .irq_line_o (irq_line)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      irq_line_q      <= irq_line;
      bank_update_q   <= ctl.bank_we;
      bank_slot_q     <= ctl.bank_we ? ctl.slot : 4'd0;
      bank_number_q   <= ctl.bank_we ? number : 8'd0;
      mirror_update_q <= ctl.mirror_we;
      mirroring_q     <= ctl.mirror_we ? value_q[1:0] : 2'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign irq_line_o      = irq_line_q;
  assign bank_update_o   = bank_update_q;
  assign bank_slot_o     = bank_slot_q;
  assign bank_number_o   = bank_number_q;
  assign mirror_update_o = mirror_update_q;
  assign mirroring_o     = mirroring_q;

endmodule

`default_nettype wire

>>> rtl/core/nbm_decode.sv
`default_nettype none

module nbm_decode (
  input  wire logic         fire_i,
  input  wire logic         mode_i,
  input  wire logic [15:0]  address_i,
  output nbm_pkg::ctl_t     ctl_o
);
  import nbm_pkg::*;

  logic [3:0] page;
  logic [1:0] low;
  logic [1:0] chr_pair;

  assign page     = address_i[15:12];
  assign low      = address_i[1:0];
  assign chr_pair = page[1:0] - 2'd2;

  always_comb begin
    ctl_o         = '0;
    ctl_o.hi      = low[0];
    ctl_o.nib_sel = low;
    if (fire_i) begin
      if (mode_i) begin
        ctl_o.tick = 1'b1;
      end else begin
        unique case (page) inside
          PagePrgA: begin
            ctl_o.bank_we = 1'b1;
            ctl_o.slot    = {3'b000, low[1]};
          end
          PagePrgB: begin
            ctl_o.bank_we = !low[1];
            ctl_o.slot    = 4'd2;
          end
          PageChr0, PageChr1, PageChr2, PageChr3: begin
            ctl_o.bank_we = 1'b1;
            ctl_o.slot    = ChrSlotBase + {1'b0, chr_pair, low[1]};
          end
          PageRel: begin
            ctl_o.reload_we = 1'b1;
          end
          PageCtl: begin
            unique case (low)
              RegCntLoad: ctl_o.count_load = 1'b1;
              RegIrqCtrl: ctl_o.ctrl_we    = 1'b1;
              RegMirror:  ctl_o.mirror_we  = 1'b1;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nbm_banks.sv
`default_nettype none

module nbm_banks (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nbm_pkg::ctl_t ctl_i,
  input  wire logic [3:0]    nib_i,
  output logic [7:0]         number_o
);
  import nbm_pkg::*;

  logic [7:0] bank_q [NumBanks];
  logic [7:0] old_val;

  assign old_val  = bank_q[ctl_i.slot];
  assign number_o = ctl_i.hi ? {nib_i, old_val[3:0]} : {old_val[7:4], nib_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBanks; i++) begin
        bank_q[i] <= '0;
      end
    end else if (ctl_i.bank_we) begin
      bank_q[ctl_i.slot] <= number_o;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nbm_irq.sv
`default_nettype none

module nbm_irq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nbm_pkg::ctl_t ctl_i,
  input  wire logic [3:0]    nib_i,
  output logic               irq_line_o
);
  import nbm_pkg::*;

  logic [15:0] reload_q, reload_d;
  logic [15:0] count_q, count_d;
  logic [15:0] mask_q, mask_d;
  logic        enabled_q, enabled_d;
  logic        pending_q, pending_d;
  logic [15:0] count_dec;

  assign count_dec = count_q - 16'd1;

  always_comb begin
    reload_d  = reload_q;
    count_d   = count_q;
    mask_d    = mask_q;
    enabled_d = enabled_q;
    pending_d = pending_q;

    if (ctl_i.tick) begin
      // The masked count stops at zero; being nonzero it never borrows past the mask.
      if (enabled_q && ((count_q & mask_q) != 16'd0)) begin
        count_d = count_dec;
        if ((count_dec & mask_q) == 16'd0) begin
          enabled_d = 1'b0;
          pending_d = 1'b1;
        end
      end
    end
    if (ctl_i.reload_we) begin
      case (ctl_i.nib_sel)
        2'd0:    reload_d[3:0]   = nib_i;
        2'd1:    reload_d[7:4]   = nib_i;
        2'd2:    reload_d[11:8]  = nib_i;
        default: reload_d[15:12] = nib_i;
      endcase
    end
    if (ctl_i.count_load) begin
      count_d   = reload_q;
      pending_d = 1'b0;
    end
    if (ctl_i.ctrl_we) begin
      enabled_d = nib_i[0];
      pending_d = 1'b0;
      if (nib_i[3]) begin
        mask_d = Mask4;
      end else if (nib_i[2]) begin
        mask_d = Mask8;
      end else if (nib_i[1]) begin
        mask_d = Mask12;
      end else begin
        mask_d = Mask16;
      end
    end
  end

  assign irq_line_o = pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q  <= '0;
      count_q   <= '0;
      mask_q    <= '0;
      enabled_q <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      reload_q  <= reload_d;
      count_q   <= count_d;
      mask_q    <= mask_d;
      enabled_q <= enabled_d;
      pending_q <= pending_d;
    end
  end

endmodule

`default_nettype wire
